// ===== sv/bps_pkg.sv =====
package bps_pkg;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_TABLE   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [2:0] FLD_TIME       = 3'd0;
    localparam logic [2:0] FLD_WEIGHT     = 3'd1;
    localparam logic [2:0] FLD_PRES_ABOVE = 3'd2;
    localparam logic [2:0] FLD_PRES_BELOW = 3'd3;
    localparam logic [2:0] FLD_WATER      = 3'd4;
    localparam logic [2:0] FLD_FLOW_ABOVE = 3'd5;
    localparam logic [2:0] FLD_FLOW_BELOW = 3'd6;

    localparam logic [1:0] CFG_PHASE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_GLOBAL_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_GLOBAL_TIME  = 2'd2;
    localparam logic [1:0] CFG_GLOBAL_WATER = 2'd3;

    // scale reading above 0.4 g selects scale flow
    localparam logic [15:0] FLOW_SRC_MIN = 16'd40;

    typedef struct packed {
        logic signed [31:0] time_lim;
        logic [15:0]        weight_lim;
        logic [15:0]        water_lim;
        logic [15:0]        pres_above;
        logic [15:0]        pres_below;
        logic [15:0]        flow_above;
        logic [15:0]        flow_below;
    } limits_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  slot;
        logic [2:0]  field;
        logic [31:0] value;
    } tbl_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v <= 32'sd0) begin
            r = 16'd0;
        end
        else if (v > 32'sd65535) begin
            r = 16'hFFFF;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/bps_limit_mem.sv =====
module bps_limit_mem #(
    parameter int MAX_PHASES = 8,
    parameter int AW = 3
) (
    input  logic              clk,
    input  bps_pkg::tbl_wr_t  wr,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output bps_pkg::limits_t  rd_data
);

    bps_pkg::limits_t limit_mem [MAX_PHASES];
    bps_pkg::limits_t rd_data_reg;

    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_half;

    assign wr_ok   = wr.en && ({29'd0, wr.slot} < 32'(MAX_PHASES));
    assign wr_addr = AW'(wr.slot);
    assign wr_half = bps_pkg::sat16($signed(wr.value));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            case (wr.field)
                bps_pkg::FLD_TIME:       limit_mem[wr_addr].time_lim   <= $signed(wr.value);
                bps_pkg::FLD_WEIGHT:     limit_mem[wr_addr].weight_lim <= wr_half;
                bps_pkg::FLD_PRES_ABOVE: limit_mem[wr_addr].pres_above <= wr_half;
                bps_pkg::FLD_PRES_BELOW: limit_mem[wr_addr].pres_below <= wr_half;
                bps_pkg::FLD_WATER:      limit_mem[wr_addr].water_lim  <= wr_half;
                bps_pkg::FLD_FLOW_ABOVE: limit_mem[wr_addr].flow_above <= wr_half;
                bps_pkg::FLD_FLOW_BELOW: limit_mem[wr_addr].flow_below <= wr_half;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= limit_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/brew_phase_sequencer_core.sv =====
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    kind, phase_slot, table_field, table_value, sensors
// out       out  out_valid/out_ready  phase_index, finished, time_in_phase
// cfg       in   cfg_write            cfg_index, cfg_data
//
// Tick item: evaluated phase by phase until no limit hits or the shot is finished, then emitted;
// one limit-table read per phase checked, one read port.
// Table write, restart and unknown items skip evaluation and go straight to emit.
// Async active-low reset; limit table is not cleared and must be loaded.
// Result sits in an output register; next item is taken while it waits.
module brew_phase_sequencer_core #(
    parameter int MAX_PHASES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [2:0]         phase_slot,
    input  logic [2:0]         table_field,
    input  logic signed [31:0] table_value,
    input  logic [30:0]        time_in_shot,
    input  logic [15:0]        scale_weight,
    input  logic signed [15:0] weight_flow,
    input  logic signed [15:0] pump_flow,
    input  logic [15:0]        shot_weight,
    input  logic [10:0]        pressure,
    input  logic [15:0]        water_pumped,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         phase_index,
    output logic               finished,
    output logic [31:0]        time_in_phase,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CW = $clog2(MAX_PHASES + 1);
    localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;

    bps_pkg::state_t state_reg, state_next;

    logic [3:0]         phase_count_reg;
    logic [15:0]        gweight_reg;
    logic signed [31:0] gtime_reg;
    logic [15:0]        gwater_reg;

    logic [CW-1:0] cur_reg, cur_next;
    logic [30:0]   start_time_reg, start_time_next;
    logic [15:0]   start_water_reg, start_water_next;
    logic [31:0]   tip_reg, tip_next;

    logic [30:0]        t_reg;
    logic [15:0]        shot_reg;
    logic [10:0]        pres_reg;
    logic [15:0]        water_reg;
    logic signed [15:0] flow_reg;
    logic signed [15:0] pflow_reg;
    logic               gstop_reg;

    logic          out_valid_reg;
    logic [2:0]    phase_index_reg;
    logic          finished_reg;
    logic [31:0]   time_in_phase_reg;

    logic in_acc, accept_tick, eval_done, emit_load, rd_en;
    logic [CW-1:0] count, rd_phase;
    logic [AW-1:0] rd_addr;
    bps_pkg::tbl_wr_t tbl_wr;
    bps_pkg::limits_t lim;

    // effective phase count
    always_comb
    begin
        if (phase_count_reg == 4'd0)
        begin
            count = CW'(1);
        end
        else if ({28'd0, phase_count_reg} > 32'(MAX_PHASES))
        begin
            count = CW'(MAX_PHASES);
        end
        else
        begin
            count = CW'(phase_count_reg);
        end
    end

    assign in_acc      = in_valid && in_ready;
    assign accept_tick = in_acc && (kind == bps_pkg::KIND_TICK);

    // global stops from the incoming item
    logic signed [15:0] flow_in;
    logic signed [19:0] flow_in_w, shot_in2, gw2;
    logic               gstop_in;

    assign flow_in   = (scale_weight > bps_pkg::FLOW_SRC_MIN) ? weight_flow : pump_flow;
    assign flow_in_w = {{4{flow_in[15]}}, flow_in};
    assign shot_in2  = $signed({3'd0, shot_weight, 1'b0});
    assign gw2       = $signed({3'd0, gweight_reg, 1'b0});
    assign gstop_in  = ((gweight_reg != 16'd0) && (shot_in2 > gw2 - flow_in_w))
                    || ((gwater_reg != 16'd0) && (water_pumped > gwater_reg))
                    || (!gtime_reg[31] && ({1'b0, time_in_shot} >= gtime_reg[31:0]));

    // phase limit check against the table entry just read
    logic signed [32:0] dt, tl_w;
    logic signed [16:0] dw;
    logic signed [19:0] flow_w, shot2, wl2, dw2, wal2;
    logic               hit, cur_fin;

    assign dt     = $signed({2'd0, t_reg}) - $signed({2'd0, start_time_reg});
    assign tl_w   = $signed({lim.time_lim[31], lim.time_lim});
    assign dw     = $signed({1'b0, water_reg}) - $signed({1'b0, start_water_reg});
    assign flow_w = {{4{flow_reg[15]}}, flow_reg};
    assign shot2  = $signed({3'd0, shot_reg, 1'b0});
    assign wl2    = $signed({3'd0, lim.weight_lim, 1'b0});
    assign dw2    = {{2{dw[16]}}, dw, 1'b0};
    assign wal2   = $signed({3'd0, lim.water_lim, 1'b0});

    assign hit = (!lim.time_lim[31] && (dt >= tl_w))
              || ((lim.weight_lim != 16'd0) && (shot2 > wl2 - flow_w))
              || ((lim.pres_above != 16'd0) && ({5'd0, pres_reg} > lim.pres_above))
              || ((lim.pres_below != 16'd0) && ({5'd0, pres_reg} < lim.pres_below))
              || ((lim.water_lim != 16'd0) && (dw2 > wal2 - flow_w))
              || ((lim.flow_above != 16'd0)
                  && ($signed({pflow_reg[15], pflow_reg}) > $signed({1'b0, lim.flow_above})))
              || ((lim.flow_below != 16'd0)
                  && ($signed({pflow_reg[15], pflow_reg}) < $signed({1'b0, lim.flow_below})));

    assign cur_fin   = (cur_reg >= count) || gstop_reg;
    assign eval_done = cur_fin || !hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bps_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (kind == bps_pkg::KIND_TICK) ? bps_pkg::ST_EVAL
                                                              : bps_pkg::ST_EMIT;
                end
            end
            bps_pkg::ST_EVAL:
            begin
                if (eval_done)
                begin
                    state_next = bps_pkg::ST_EMIT;
                end
            end
            bps_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = bps_pkg::ST_IDLE;
                end
            end
            default: state_next = bps_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        emit_load = 1'b0;
        rd_en     = 1'b0;
        rd_phase  = cur_reg;
        case (state_reg)
            bps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = accept_tick;
            end
            bps_pkg::ST_EVAL:
            begin
                rd_en    = !eval_done;
                rd_phase = cur_reg + CW'(1);
            end
            bps_pkg::ST_EMIT:
            begin
                emit_load = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    assign rd_addr = ({{(32 - CW){1'b0}}, rd_phase} < 32'(MAX_PHASES)) ? AW'(rd_phase)
                                                                       : '0;

    assign tbl_wr.en    = in_acc && (kind == bps_pkg::KIND_TABLE);
    assign tbl_wr.slot  = phase_slot;
    assign tbl_wr.field = table_field;
    assign tbl_wr.value = table_value;

    bps_limit_mem #(
        .MAX_PHASES (MAX_PHASES),
        .AW         (AW)
    ) u_mem (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (lim)
    );

    // phase state updates
    always_comb
    begin
        cur_next         = cur_reg;
        start_time_next  = start_time_reg;
        start_water_next = start_water_reg;
        tip_next         = tip_reg;
        if (state_reg == bps_pkg::ST_IDLE && in_acc)
        begin
            tip_next = 32'd0;
            if (kind == bps_pkg::KIND_RESTART)
            begin
                cur_next         = '0;
                start_time_next  = '0;
                start_water_next = '0;
            end
        end
        else if (state_reg == bps_pkg::ST_EVAL)
        begin
            if (cur_fin)
            begin
                cur_next = count;
                tip_next = {1'b0, t_reg} - {1'b0, start_time_reg};
            end
            else if (!hit)
            begin
                tip_next = {1'b0, t_reg} - {1'b0, start_time_reg};
            end
            else
            begin
                cur_next         = cur_reg + CW'(1);
                start_time_next  = t_reg;
                start_water_next = water_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bps_pkg::ST_IDLE;
            phase_count_reg <= 4'd1;
            gweight_reg     <= 16'd0;
            gtime_reg       <= -32'sd1;
            gwater_reg      <= 16'd0;
            cur_reg         <= '0;
            start_time_reg  <= '0;
            start_water_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            start_time_reg  <= start_time_next;
            start_water_reg <= start_water_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    bps_pkg::CFG_PHASE_COUNT:   phase_count_reg <= cfg_data[3:0];
                    bps_pkg::CFG_GLOBAL_WEIGHT: gweight_reg     <= cfg_data[15:0];
                    bps_pkg::CFG_GLOBAL_TIME:   gtime_reg       <= $signed(cfg_data);
                    bps_pkg::CFG_GLOBAL_WATER:  gwater_reg      <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic          fin_now;
    logic [CW-1:0] idx_now;

    assign fin_now = cur_reg >= count;
    assign idx_now = fin_now ? count - CW'(1) : cur_reg;

    always_ff @(posedge clk)
    begin
        tip_reg <= tip_next;
        if (accept_tick)
        begin
            t_reg     <= time_in_shot;
            shot_reg  <= shot_weight;
            pres_reg  <= pressure;
            water_reg <= water_pumped;
            flow_reg  <= flow_in;
            pflow_reg <= pump_flow;
            gstop_reg <= gstop_in;
        end
        if (emit_load)
        begin
            phase_index_reg   <= 3'(idx_now);
            finished_reg      <= fin_now;
            time_in_phase_reg <= tip_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase_index   = phase_index_reg;
    assign finished      = finished_reg;
    assign time_in_phase = time_in_phase_reg;

endmodule
